// ----- design/s20ks_pkg.sv -----
// shared types and constants for the salsa20 keystream generator
// used by the front end, queue, round engine and top level, no dependencies

package s20ks_pkg;

	// salsa20 "expand 32-byte k" constants
	localparam logic [31:0] SIG0 = 32'h6170_7865;
	localparam logic [31:0] SIG1 = 32'h3320_646e;
	localparam logic [31:0] SIG2 = 32'h7962_2d32;
	localparam logic [31:0] SIG3 = 32'h6b20_6574;

	localparam int NUM_REGS        = 5;
	localparam int CFG_ADDR_W      = 6;
	localparam int CFG_DATA_W      = 64;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int NBYTES_W        = 7;
	localparam logic [NBYTES_W-1:0] BLOCK_BYTES = 7'd64;

	typedef enum logic [2:0] {
		REG_KEY01 = 3'd0,
		REG_KEY23 = 3'd1,
		REG_KEY45 = 3'd2,
		REG_KEY67 = 3'd3,
		REG_NONCE = 3'd4
	} reg_idx_t;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce;
	} cfg_t;

	// one block request as it travels through the queue
	typedef struct packed {
		logic [NBYTES_W-1:0] nbytes;
		logic [63:0]         counter;
	} req_t;

endpackage

// ----- design/s20ks_front.sv -----
// request front end: takes byte counts, drops empty ones, saturates,
// and tags each block with the block counter; uses s20ks_pkg

module s20ks_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_clear,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	output logic                push_valid,
	input  logic                push_ready,
	output s20ks_pkg::req_t     push_req
);

	logic [63:0]                      counter_q;
	logic [s20ks_pkg::NBYTES_W-1:0]   nbytes;
	logic                             nonzero;

	// counts above one block are clipped to one block
	always_comb begin
		nbytes = s_tdata[s20ks_pkg::NBYTES_W-1:0];
		if (nbytes > s20ks_pkg::BLOCK_BYTES) begin
			nbytes = s20ks_pkg::BLOCK_BYTES;
		end
		nonzero = (nbytes != '0);
	end

	assign s_tready        = push_ready;
	assign push_valid      = s_tvalid && nonzero;
	assign push_req.nbytes = nbytes;
	assign push_req.counter = counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (cfg_clear) begin
			counter_q <= '0;
		end else if (push_valid && push_ready) begin
			counter_q <= counter_q + 64'd1;
		end
	end

endmodule

// ----- design/s20ks_queue.sv -----
// short request queue between front end and round engine
// uses s20ks_pkg for the entry type

module s20ks_queue #(
	parameter int DEPTH = s20ks_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  s20ks_pkg::req_t push_req,
	output logic            pop_valid,
	input  logic            pop_ready,
	output s20ks_pkg::req_t pop_req
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	s20ks_pkg::req_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_req    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/s20ks_back.sv -----
// round engine and word serialiser: one double round a cycle, feed-forward,
// then a block buffer drained as 64-bit words; uses s20ks_pkg

module s20ks_back (
	input  logic            clk,
	input  logic            arst_n,
	input  s20ks_pkg::cfg_t cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  s20ks_pkg::req_t pop_req,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [63:0]     m_tdata,
	output logic [3:0]      m_tuser,
	output logic            m_tlast
);

	localparam logic [3:0] DOUBLE_ROUNDS = 4'd10;

	typedef logic [3:0][31:0] quad_t;
	typedef enum logic [1:0] {ENG_IDLE, ENG_ROUND, ENG_DONE} eng_state_t;

	// column round then row round, word order a, b, c, d
	localparam logic [3:0] QIDX [8][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1},
		'{4'd10, 4'd14, 4'd2,  4'd6},
		'{4'd15, 4'd3,  4'd7,  4'd11},
		'{4'd0,  4'd1,  4'd2,  4'd3},
		'{4'd5,  4'd6,  4'd7,  4'd4},
		'{4'd10, 4'd11, 4'd8,  4'd9},
		'{4'd15, 4'd12, 4'd13, 4'd14}
	};

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic quad_t quarter(input quad_t q);
		quad_t r;
		r = q;
		r[1] = r[1] ^ rotl(r[0] + r[3], 7);
		r[2] = r[2] ^ rotl(r[1] + r[0], 9);
		r[3] = r[3] ^ rotl(r[2] + r[1], 13);
		r[0] = r[0] ^ rotl(r[3] + r[2], 18);
		return r;
	endfunction

	function automatic s20ks_pkg::state_t dround(input s20ks_pkg::state_t s);
		s20ks_pkg::state_t x;
		quad_t             q;
		x = s;
		for (int i = 0; i < 8; i++) begin
			q = quarter({x[QIDX[i][3]], x[QIDX[i][2]], x[QIDX[i][1]], x[QIDX[i][0]]});
			x[QIDX[i][0]] = q[0];
			x[QIDX[i][1]] = q[1];
			x[QIDX[i][2]] = q[2];
			x[QIDX[i][3]] = q[3];
		end
		return x;
	endfunction

	function automatic s20ks_pkg::state_t init_matrix(input s20ks_pkg::cfg_t c,
			input logic [63:0] ctr);
		s20ks_pkg::state_t m;
		m[0]  = s20ks_pkg::SIG0;
		m[1]  = c.key[0][31:0];
		m[2]  = c.key[0][63:32];
		m[3]  = c.key[1][31:0];
		m[4]  = c.key[1][63:32];
		m[5]  = s20ks_pkg::SIG1;
		m[6]  = c.nonce[31:0];
		m[7]  = c.nonce[63:32];
		m[8]  = ctr[31:0];
		m[9]  = ctr[63:32];
		m[10] = s20ks_pkg::SIG2;
		m[11] = c.key[2][31:0];
		m[12] = c.key[2][63:32];
		m[13] = c.key[3][31:0];
		m[14] = c.key[3][63:32];
		m[15] = s20ks_pkg::SIG3;
		return m;
	endfunction

	eng_state_t                      eng_state_q;
	logic [3:0]                      round_q;
	s20ks_pkg::state_t               x_q;
	logic [63:0]                     ctr_q;
	logic [s20ks_pkg::NBYTES_W-1:0]  nb_eng_q;

	s20ks_pkg::state_t               buf_q;
	logic                            buf_full_q;
	logic [s20ks_pkg::NBYTES_W-1:0]  nb_buf_q;
	logic [2:0]                      widx_q;

	logic                            out_valid_q;
	logic [63:0]                     out_data_q;
	logic [3:0]                      out_user_q;
	logic                            out_last_q;

	s20ks_pkg::state_t               ff_init;
	logic [s20ks_pkg::NBYTES_W-1:0]  remain;
	logic [3:0]                      cur_valid;
	logic                            cur_last;
	logic [63:0]                     cur_word;
	logic                            out_load;
	logic                            buf_free;
	logic                            xfer;
	logic                            take;

	// current word of the buffer, trimmed to the bytes still owed
	always_comb begin
		remain    = nb_buf_q - {1'b0, widx_q, 3'b000};
		cur_last  = (remain <= 7'd8);
		cur_valid = cur_last ? remain[3:0] : 4'd8;
		cur_word  = {buf_q[{widx_q, 1'b1}], buf_q[{widx_q, 1'b0}]};
		for (int b = 0; b < 8; b++) begin
			if (4'(b) >= cur_valid) begin
				cur_word[8*b +: 8] = 8'h00;
			end
		end
	end

	assign ff_init   = init_matrix(cfg, ctr_q);
	assign out_load  = buf_full_q && (!out_valid_q || m_tready);
	assign buf_free  = !buf_full_q || (out_load && cur_last);
	assign xfer      = (eng_state_q == ENG_DONE) && buf_free;
	assign pop_ready = (eng_state_q == ENG_IDLE) || xfer;
	assign take      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_state_q <= ENG_IDLE;
			round_q     <= '0;
		end else begin
			unique case (eng_state_q)
				ENG_IDLE: begin
					if (take) begin
						eng_state_q <= ENG_ROUND;
						round_q     <= '0;
					end
				end
				ENG_ROUND: begin
					round_q <= round_q + 4'd1;
					if (round_q == DOUBLE_ROUNDS - 4'd1) begin
						eng_state_q <= ENG_DONE;
					end
				end
				ENG_DONE: begin
					if (take) begin
						eng_state_q <= ENG_ROUND;
						round_q     <= '0;
					end else if (xfer) begin
						eng_state_q <= ENG_IDLE;
					end
				end
				default: eng_state_q <= ENG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q      <= init_matrix(cfg, pop_req.counter);
			ctr_q    <= pop_req.counter;
			nb_eng_q <= pop_req.nbytes;
		end else if (eng_state_q == ENG_ROUND) begin
			x_q <= dround(x_q);
		end
	end

	// feed-forward add as the block moves into the buffer
	always_ff @(posedge clk) begin
		if (xfer) begin
			for (int i = 0; i < 16; i++) begin
				buf_q[i] <= x_q[i] + ff_init[i];
			end
			nb_buf_q <= nb_eng_q;
		end
		if (out_load) begin
			out_data_q <= cur_word;
			out_user_q <= cur_valid;
			out_last_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_full_q  <= 1'b0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				buf_full_q <= 1'b1;
				widx_q     <= '0;
			end else if (out_load) begin
				widx_q <= widx_q + 3'd1;
				if (cur_last) begin
					buf_full_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- design/salsa20_keystream_generator_core.sv -----
// top level of the salsa20/20 keystream generator: register port, front end,
// request queue and round engine; uses s20ks_pkg, s20ks_front, s20ks_queue, s20ks_back

// Salsa20/20 keystream generator, 256-bit key, 64-bit nonce, 64-bit block
// counter. Each item on the slave stream asks for 0 to 64 bytes of keystream
// from the next block (counts above 64 are clipped to 64, a count of zero is
// dropped and leaves the counter alone). Each non-empty item produces one
// 64-byte block, sent on the master stream as up to eight little-endian
// 64-bit words, first byte in bits 7:0, unused upper bytes of a short final
// word zero, tuser giving the number of valid bytes and tlast marking the
// final word; the counter then steps by one and wraps at 2^64. No data is
// xored in. From acceptance, a block is loaded, runs ten double rounds,
// takes the feed-forward add as it moves into the block buffer and leaves
// via the output register; the next block loads during that move, not before.
// Words drain from a block buffer while the next block is computed, and a
// short request queue keeps items flowing in meanwhile. Key and nonce sit in
// five 64-bit registers at byte addresses 0, 8, 16, 24 (key words 0/1 .. 6/7,
// even word low) and 32 (nonce); any write to one of them clears the block
// counter. Registers are only to be written while the block is idle.

module salsa20_keystream_generator_core #(
	parameter int QUEUE_DEPTH = s20ks_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [s20ks_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [s20ks_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [s20ks_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // byte_count[6:0], zero pad
	// keystream stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [63:0]                      m_tdata,   // keystream_word[63:0]
	output logic [3:0]                       m_tuser,   // valid_bytes[3:0]
	output logic                             m_tlast    // last_word
);

	s20ks_pkg::cfg_t      cfg_q;
	s20ks_pkg::reg_idx_t  reg_idx;
	logic                 wr_en;
	logic                 cfg_clear;

	s20ks_pkg::req_t      push_req;
	s20ks_pkg::req_t      pop_req;
	logic                 push_valid;
	logic                 push_ready;
	logic                 pop_valid;
	logic                 pop_ready;

	// registers are 64 bits wide, so the index sits above the byte offset
	assign reg_idx = s20ks_pkg::reg_idx_t'(paddr[s20ks_pkg::CFG_ADDR_W-1:3]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// only listed registers clear the counter
	always_comb begin
		cfg_clear = 1'b0;
		prdata    = '0;
		unique case (reg_idx)
			s20ks_pkg::REG_KEY01: begin
				cfg_clear = wr_en;
				prdata    = cfg_q.key[0];
			end
			s20ks_pkg::REG_KEY23: begin
				cfg_clear = wr_en;
				prdata    = cfg_q.key[1];
			end
			s20ks_pkg::REG_KEY45: begin
				cfg_clear = wr_en;
				prdata    = cfg_q.key[2];
			end
			s20ks_pkg::REG_KEY67: begin
				cfg_clear = wr_en;
				prdata    = cfg_q.key[3];
			end
			s20ks_pkg::REG_NONCE: begin
				cfg_clear = wr_en;
				prdata    = cfg_q.nonce;
			end
			default: begin
				cfg_clear = 1'b0;
				prdata    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				s20ks_pkg::REG_KEY01: cfg_q.key[0] <= pwdata;
				s20ks_pkg::REG_KEY23: cfg_q.key[1] <= pwdata;
				s20ks_pkg::REG_KEY45: cfg_q.key[2] <= pwdata;
				s20ks_pkg::REG_KEY67: cfg_q.key[3] <= pwdata;
				s20ks_pkg::REG_NONCE: cfg_q.nonce  <= pwdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// front end: drops empty requests and tags blocks with the counter
	s20ks_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_clear  (cfg_clear),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req)
	);

	// decouples request intake from the round engine
	s20ks_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	// round engine, block buffer and output register
	s20ks_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_req   (pop_req),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- design/s20ks_checker.sv -----
// port-level checks on the keystream output of the generator
// bound to salsa20_keystream_generator_core, no package dependency

module s20ks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// nothing leaves the block while reset is held
	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output word changed");

	// only the last word of a block may be short
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == 4'd8)
		else $error("short word not marked last");

	// byte count in range, and unused top byte of a short word is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 4'd0 && m_tuser <= 4'd8
			&& (m_tuser == 4'd8 || m_tdata[63:56] == 8'h00))
		else $error("bad valid byte count or unmasked byte");

endmodule

bind salsa20_keystream_generator_core s20ks_checker u_s20ks_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
